// ===== rtl/keyed_pairing_table_core_defines.svh =====
// Assertion macros used by the table core to check its own logic.
`ifndef KEYED_PAIRING_TABLE_CORE_DEFINES_SVH
`define KEYED_PAIRING_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPT_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KPT_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/kpt_pkg.sv =====
package kpt_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    typedef enum logic [2:0] {
        OP_LOOKUP   = 3'd0,
        OP_SET      = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_ARM      = 3'd3,
        OP_COMPLETE = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_ACT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] device_id;
        logic [7:0]  button;
        logic [15:0] station_in;
        logic [7:0]  speed_in;
        logic [31:0] now_seconds;
        logic [31:0] window_seconds;
    } t_in_word;

    typedef struct packed {
        logic        ok;
        logic [15:0] found_station;
        logic [7:0]  found_speed;
        logic [4:0]  used_count;
    } t_out_word;

    typedef struct packed {
        logic [31:0] device;
        logic [7:0]  button;
        logic [15:0] station;
        logic [7:0]  speed;
    } t_entry;

    typedef struct packed {
        logic        hit;
        logic        free;
        logic [15:0] station;
        logic [7:0]  speed;
    } t_scan_flags;

endpackage

// ===== rtl/keyed_pairing_table_core.sv =====
// Keyed pairing table. Each input word is one operation (lookup, set, remove, arm a pairing
// window, or complete pairing) and yields exactly one result word. Table operations scan every
// entry through the single read port of the entry memory, one entry a cycle, with one shared
// key comparator, and then pass through the tail, act and result states; arm, a completion
// outside its window and unused codes go straight to the result state. A new word is accepted
// only once the previous result has been handed to the output register. The valid bits are
// flip-flops cleared by reset, so no clearing pass is needed after reset.
`include "keyed_pairing_table_core_defines.svh"

module keyed_pairing_table_core #(
    parameter int ENTRIES = kpt_pkg::ENTRIES_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kpt_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kpt_pkg::t_out_word  o_out_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = ($clog2(ENTRIES + 1) > 5) ? $clog2(ENTRIES + 1) : 5;

    kpt_pkg::t_state      r_state;
    kpt_pkg::t_state      n_state;
    kpt_pkg::t_in_word    r_item;
    kpt_pkg::t_out_word   r_res;
    kpt_pkg::t_out_word   n_res;

    logic [ENTRIES-1:0]   r_valid;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_step;
    logic                 r_vld_rd;

    logic                 r_win_open;
    logic [15:0]          r_win_station;
    logic [7:0]           r_win_speed;
    logic [31:0]          r_win_start;
    logic [31:0]          r_win_length;
    logic [31:0]          win_elapsed;
    logic                 win_live;

    logic                 accept;
    logic                 last_rd;
    logic                 res_load;
    logic                 act;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    kpt_pkg::t_entry      ram_wdata;
    kpt_pkg::t_entry      ram_rdata;
    logic                 set_valid;
    logic                 clr_valid;
    logic [IDX_W-1:0]     valid_idx;

    kpt_pkg::t_scan_flags scan;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     free_idx;

    function automatic logic [4:0] sat_count(input logic [CNT_W-1:0] c);
        sat_count = (c > CNT_W'(31)) ? 5'd31 : c[4:0];
    endfunction

    assign accept      = i_in_valid && o_in_ready;
    assign last_rd     = (r_rd_idx == IDX_W'(ENTRIES - 1));
    assign win_elapsed = i_in_data.now_seconds - r_win_start;
    assign win_live    = r_win_open && (win_elapsed < r_win_length);
    assign act         = (r_state == kpt_pkg::ST_ACT);

    kpt_ram #(
        .WIDTH ($bits(kpt_pkg::t_entry)),
        .DEPTH (ENTRIES)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    kpt_match #(
        .ENTRIES (ENTRIES)
    ) u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (accept),
        .i_step       (r_step),
        .i_idx        (r_cmp_idx),
        .i_slot_valid (r_vld_rd),
        .i_entry      (ram_rdata),
        .i_device     (r_item.device_id),
        .i_button     (r_item.button),
        .o_flags      (scan),
        .o_hit_idx    (hit_idx),
        .o_free_idx   (free_idx)
    );

    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        n_count   = r_count;
        o_in_ready = 1'b0;
        res_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = hit_idx;
        ram_wdata = '{device: r_item.device_id, button: r_item.button,
                      station: r_item.station_in, speed: r_item.speed_in};
        set_valid = 1'b0;
        clr_valid = 1'b0;
        valid_idx = hit_idx;

        if (r_item.op == kpt_pkg::OP_COMPLETE) begin
            ram_wdata.station = r_win_station;
            ram_wdata.speed   = r_win_speed;
        end

        unique case (r_state)
            kpt_pkg::ST_IDLE: begin
                o_in_ready = i_rst_n;
                n_res = '{ok: 1'b0, found_station: 16'd0, found_speed: 8'd0,
                          used_count: sat_count(r_count)};
                if (i_in_valid) begin
                    case (i_in_data.op) inside
                        kpt_pkg::OP_LOOKUP, kpt_pkg::OP_SET, kpt_pkg::OP_REMOVE: begin
                            n_state = kpt_pkg::ST_SCAN;
                        end
                        kpt_pkg::OP_ARM: begin
                            n_res.ok = 1'b1;
                            n_state  = kpt_pkg::ST_RESULT;
                        end
                        kpt_pkg::OP_COMPLETE: begin
                            n_state = win_live ? kpt_pkg::ST_SCAN : kpt_pkg::ST_RESULT;
                        end
                        default: begin
                            n_state = kpt_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            kpt_pkg::ST_SCAN: begin
                if (last_rd) begin
                    n_state = kpt_pkg::ST_TAIL;
                end
            end
            kpt_pkg::ST_TAIL: begin
                n_state = kpt_pkg::ST_ACT;
            end
            kpt_pkg::ST_ACT: begin
                case (r_item.op)
                    kpt_pkg::OP_LOOKUP: begin
                        n_res.ok = scan.hit;
                        if (scan.hit) begin
                            n_res.found_station = scan.station;
                            n_res.found_speed   = scan.speed;
                        end
                    end
                    kpt_pkg::OP_REMOVE: begin
                        if (scan.hit) begin
                            n_res.ok  = 1'b1;
                            clr_valid = 1'b1;
                            n_count   = r_count - CNT_W'(1);
                        end
                    end
                    default: begin
                        if (scan.hit) begin
                            n_res.ok = 1'b1;
                            ram_we   = 1'b1;
                        end else if (scan.free) begin
                            n_res.ok  = 1'b1;
                            ram_we    = 1'b1;
                            ram_waddr = free_idx;
                            set_valid = 1'b1;
                            valid_idx = free_idx;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                endcase
                n_res.used_count = sat_count(n_count);
                n_state = kpt_pkg::ST_RESULT;
            end
            kpt_pkg::ST_RESULT: begin
                if (!o_out_valid || i_out_ready) begin
                    res_load = 1'b1;
                    n_state  = kpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_count       <= '0;
            r_step        <= 1'b0;
            o_out_valid   <= 1'b0;
            r_win_open    <= 1'b0;
            r_win_station <= '0;
            r_win_speed   <= '0;
            r_win_start   <= '0;
            r_win_length  <= '0;
        end else begin
            r_step  <= (r_state == kpt_pkg::ST_SCAN);
            r_count <= n_count;
            if (set_valid) begin
                r_valid[valid_idx] <= 1'b1;
            end
            if (clr_valid) begin
                r_valid[valid_idx] <= 1'b0;
            end
            if (res_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (accept && (i_in_data.op == kpt_pkg::OP_ARM)) begin
                r_win_open    <= 1'b1;
                r_win_station <= i_in_data.station_in;
                r_win_speed   <= i_in_data.speed_in;
                r_win_start   <= i_in_data.now_seconds;
                r_win_length  <= i_in_data.window_seconds;
            end
            if (act && (r_item.op == kpt_pkg::OP_COMPLETE)) begin
                r_win_open <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= i_in_data;
            r_rd_idx <= '0;
        end else if ((r_state == kpt_pkg::ST_SCAN) && !last_rd) begin
            r_rd_idx <= r_rd_idx + IDX_W'(1);
        end
        r_cmp_idx <= r_rd_idx;
        r_vld_rd  <= r_valid[r_rd_idx];
        r_res     <= n_res;
        if (res_load) begin
            o_out_data <= r_res;
        end
    end

    `KPT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(ENTRIES), "used count exceeds table size")
    `KPT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_in_ready, "input accepted again before the result was produced")
    `KPT_ASSERT_NEXT(a_window_closes, i_clk, i_rst_n, act && (r_item.op == kpt_pkg::OP_COMPLETE), !r_win_open, "pairing window still open after completion")

endmodule

// ===== rtl/kpt_ram.sv =====
module kpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/kpt_match.sv =====
module kpt_match #(
    parameter int ENTRIES = kpt_pkg::ENTRIES_DEFAULT
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_clear,
    input  logic                                         i_step,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] i_idx,
    input  logic                                         i_slot_valid,
    input  kpt_pkg::t_entry                              i_entry,
    input  logic [31:0]                                  i_device,
    input  logic [7:0]                                   i_button,
    output kpt_pkg::t_scan_flags                         o_flags,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] o_hit_idx,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] o_free_idx
);

    logic                 r_hit;
    logic                 r_free;
    logic [15:0]          r_station;
    logic [7:0]           r_speed;
    logic                 is_match;

    assign is_match = i_slot_valid && (i_entry.device == i_device)
                      && (i_entry.button == i_button);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_step) begin
            if (is_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (!i_slot_valid && !r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && is_match && !r_hit) begin
            o_hit_idx <= i_idx;
            r_station <= i_entry.station;
            r_speed   <= i_entry.speed;
        end
        if (i_step && !i_slot_valid && !r_free) begin
            o_free_idx <= i_idx;
        end
    end

    assign o_flags = '{hit: r_hit, free: r_free, station: r_station, speed: r_speed};

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kpt_pkg::*;

    localparam int ENTRIES = ENTRIES_DEFAULT;
    localparam int POOL = 24;
    localparam int RANDOM_WORDS = 400;
    localparam int MIX_LENGTH = 40;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_CHURN} t_mix;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word res;
    } t_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    // Predicted contents of the table and of the pairing window.
    logic        slot_live [ENTRIES];
    t_entry      slot_tab [ENTRIES];
    logic        win_open;
    logic [15:0] win_station;
    logic [7:0]  win_speed;
    logic [31:0] win_start;
    logic [31:0] win_length;

    logic [31:0] pool_dev [POOL];
    logic [7:0]  pool_btn [POOL];

    t_out_word   pending_results [$];
    t_out_word   due_word;
    t_row        row_q [$];
    logic [15:0] stall_cyc = '0;

    int fail_count = 0;
    int words_sent = 0;
    int results_seen = 0;
    int lookup_hits = 0;
    int pairings_done = 0;
    int full_refusals = 0;
    int burst_left = 0;
    bit calm = 1'b0;
    int fill_idx = 0;

    keyed_pairing_table_core #(
        .ENTRIES(ENTRIES)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results still outstanding.", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int find_key(logic [31:0] dev, logic [7:0] btn);
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && slot_tab[i].device == dev && slot_tab[i].button == btn) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic bit store_key(logic [31:0] dev, logic [7:0] btn,
                                     logic [15:0] st, logic [7:0] sp);
        int hit;
        hit = find_key(dev, btn);
        if (hit >= 0) begin
            slot_tab[hit].station = st;
            slot_tab[hit].speed = sp;
            return 1'b1;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_live[i]) begin
                slot_live[i] = 1'b1;
                slot_tab[i].device = dev;
                slot_tab[i].button = btn;
                slot_tab[i].station = st;
                slot_tab[i].speed = sp;
                return 1'b1;
            end
        end
        full_refusals++;
        return 1'b0;
    endfunction

    function automatic t_out_word predict_table_op(t_in_word w);
        t_out_word   r;
        int          hit;
        int          used;
        logic [31:0] elapsed;
        r = '0;
        case (w.op)
            OP_LOOKUP: begin
                hit = find_key(w.device_id, w.button);
                if (hit >= 0) begin
                    r.ok = 1'b1;
                    r.found_station = slot_tab[hit].station;
                    r.found_speed = slot_tab[hit].speed;
                    lookup_hits++;
                end
            end
            OP_SET: begin
                r.ok = store_key(w.device_id, w.button, w.station_in, w.speed_in);
            end
            OP_REMOVE: begin
                hit = find_key(w.device_id, w.button);
                if (hit >= 0) begin
                    slot_live[hit] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            OP_ARM: begin
                win_open = 1'b1;
                win_station = w.station_in;
                win_speed = w.speed_in;
                win_start = w.now_seconds;
                win_length = w.window_seconds;
                r.ok = 1'b1;
            end
            OP_COMPLETE: begin
                elapsed = w.now_seconds - win_start;
                if (win_open && elapsed < win_length) begin
                    r.ok = store_key(w.device_id, w.button, win_station, win_speed);
                    win_open = 1'b0;
                    if (r.ok) begin
                        pairings_done++;
                    end
                end
            end
            default: begin
            end
        endcase
        used = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            used += slot_live[i] ? 1 : 0;
        end
        r.used_count = (used > 31) ? 5'd31 : 5'(used);
        return r;
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            stall_cyc <= stall_cyc + 16'd1;
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("Result word %h arrived with nothing expected", out_word);
                    fail_count++;
                end else begin
                    due_word = pending_results.pop_front();
                    results_seen++;
                    compare_field("ok", 16'(due_word.ok), 16'(out_word.ok));
                    compare_field("found_station", due_word.found_station,
                                  out_word.found_station);
                    compare_field("found_speed", 16'(due_word.found_speed),
                                  16'(out_word.found_speed));
                    compare_field("used_count", 16'(due_word.used_count),
                                  16'(out_word.used_count));
                end
            end
            case (stall_cyc[9:8])
                2'd0: out_ready <= 1'b1;
                2'd1: out_ready <= 1'($urandom_range(1));
                2'd2: out_ready <= (stall_cyc[4:0] < 5'd22);
                default: out_ready <= ($urandom_range(7) != 0);
            endcase
        end
    end

    task automatic send_word(t_in_word w, bit typed, t_out_word typed_res);
        t_out_word predicted;
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        predicted = predict_table_op(w);
        pending_results.push_back(typed ? typed_res : predicted);
        words_sent++;
    endtask

    // Ends the current burst when it runs out, with a gap unless that burst was drawn as calm.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            gap = calm ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
            calm = ($urandom_range(4) == 0);
        end
    endtask

    task automatic issue(t_in_word w);
        send_word(w, 1'b0, '0);
        pace();
    endtask

    task automatic hold_until_drained();
        if (in_valid) begin
            in_valid <= 1'b0;
        end
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
    endtask

    function automatic void add_row(logic [2:0] op, logic [31:0] dev, logic [7:0] btn,
                                    logic [15:0] st, logic [7:0] sp, logic [31:0] now,
                                    logic [31:0] len, bit typed, logic ok,
                                    logic [15:0] fst, logic [7:0] fsp, logic [4:0] cnt);
        t_row r;
        r.w.op = op;
        r.w.device_id = dev;
        r.w.button = btn;
        r.w.station_in = st;
        r.w.speed_in = sp;
        r.w.now_seconds = now;
        r.w.window_seconds = len;
        r.typed = typed;
        r.res.ok = ok;
        r.res.found_station = fst;
        r.res.found_speed = fsp;
        r.res.used_count = cnt;
        row_q.push_back(r);
    endfunction

    function automatic t_in_word keyed_word(logic [2:0] op);
        t_in_word w;
        int       k;
        k = $urandom_range(POOL - 1);
        w.op = op;
        w.device_id = pool_dev[k];
        w.button = pool_btn[k];
        if ($urandom_range(7) == 0) begin
            w.device_id = $urandom;
            w.button = 8'($urandom);
        end
        w.station_in = 16'($urandom);
        w.speed_in = 8'($urandom);
        w.now_seconds = $urandom;
        w.window_seconds = $urandom;
        return w;
    endfunction

    function automatic t_in_word noise_word();
        t_in_word w;
        w = keyed_word(3'($urandom_range(7)));
        w.device_id = $urandom;
        w.button = 8'($urandom);
        return w;
    endfunction

    // Arms a window and then tries to complete it, mostly near the window's edges.
    task automatic pair_up();
        t_in_word arm_w;
        t_in_word done_w;
        arm_w = keyed_word(OP_ARM);
        case ($urandom_range(4))
            0: arm_w.window_seconds = 32'd0;
            1: arm_w.window_seconds = 32'hFFFF_FFFF;
            2, 3: arm_w.window_seconds = $urandom_range(1, 64);
            default: begin
            end
        endcase
        issue(arm_w);
        if ($urandom_range(3) == 0) begin
            issue(keyed_word(OP_LOOKUP));
        end
        done_w = keyed_word(OP_COMPLETE);
        case ($urandom_range(5))
            0: done_w.now_seconds = arm_w.now_seconds + arm_w.window_seconds - 32'd1;
            1: done_w.now_seconds = arm_w.now_seconds + arm_w.window_seconds;
            2: done_w.now_seconds = arm_w.now_seconds + $urandom_range(0, 63);
            3: done_w.now_seconds = arm_w.now_seconds;
            default: begin
            end
        endcase
        issue(done_w);
        if ($urandom_range(3) == 0) begin
            issue(done_w);
        end
        if ($urandom_range(1) == 1) begin
            done_w.op = OP_LOOKUP;
            issue(done_w);
        end
    endtask

    initial begin
        int       n_dir;
        int       cur_phase;
        int       pick;
        int       next_hold;
        int       guard;
        t_in_word w;
        t_mix     mix;

        foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_tab[i] = '0;
        end
        win_open = 1'b0;
        win_station = '0;
        win_speed = '0;
        win_start = '0;
        win_length = '0;

        // Every third key shares its device with the one before and differs only in button.
        for (int k = 0; k < POOL; k++) begin
            if (k % 3 == 1) begin
                pool_dev[k] = pool_dev[k - 1];
                pool_btn[k] = pool_btn[k - 1] ^ 8'h01;
            end else begin
                pool_dev[k] = $urandom;
                pool_btn[k] = 8'($urandom);
            end
        end

        add_row(OP_LOOKUP, 32'h0, 8'h0, 16'h0, 8'h0, 32'h0, 32'h0, 1, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_REMOVE, 32'hFFFF_FFFF, 8'hFF, 16'h0, 8'h0, 32'h0, 32'h0,
                1, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_COMPLETE, 32'h0, 8'h0, 16'h0, 8'h0, 32'h0, 32'hFFFF_FFFF,
                1, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_SPARE_LO, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_SPARE_HI, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_SET, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF, 32'h0, 32'h0,
                1, 1, 16'h0, 8'h0, 5'd1);
        add_row(OP_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 16'h0, 8'h0, 32'h0, 32'h0,
                1, 1, 16'hFFFF, 8'hFF, 5'd1);
        add_row(OP_SET, 32'h0, 8'h0, 16'h0, 8'h0, 32'h0, 32'h0, 1, 1, 16'h0, 8'h0, 5'd2);
        add_row(OP_SET, 32'h0, 8'h0, 16'h1234, 8'h56, 32'h0, 32'h0,
                1, 1, 16'h0, 8'h0, 5'd2);
        add_row(OP_LOOKUP, 32'h0, 8'h01, 16'h0, 8'h0, 32'h0, 32'h0,
                1, 0, 16'h0, 8'h0, 5'd2);
        add_row(OP_LOOKUP, 32'h0, 8'h0, 16'h0, 8'h0, 32'h0, 32'h0,
                1, 1, 16'h1234, 8'h56, 5'd2);
        add_row(OP_REMOVE, 32'hFFFF_FFFF, 8'hFF, 16'h0, 8'h0, 32'h0, 32'h0,
                1, 1, 16'h0, 8'h0, 5'd1);
        add_row(OP_SET, 32'h1, 8'h0, 16'h0001, 8'h01, 32'h0, 32'h0,
                1, 1, 16'h0, 8'h0, 5'd2);
        add_row(OP_ARM, 32'h0, 8'h0, 16'hBEEF, 8'h7F, 32'hFFFF_FFF0, 32'h20,
                0, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_COMPLETE, 32'hA5A5_A5A5, 8'h03, 16'h0, 8'h0, 32'h0000_000F, 32'h0,
                0, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_LOOKUP, 32'hA5A5_A5A5, 8'h03, 16'h0, 8'h0, 32'h0, 32'h0,
                0, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_COMPLETE, 32'hA5A5_A5A5, 8'h03, 16'h0, 8'h0, 32'h0000_000F, 32'h0,
                1, 0, 16'h0, 8'h0, 5'd3);
        add_row(OP_ARM, 32'h0, 8'h0, 16'h8000, 8'h80, 32'd100, 32'd10,
                0, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_COMPLETE, 32'h0000_0100, 8'h80, 16'h0, 8'h0, 32'd110, 32'h0,
                1, 0, 16'h0, 8'h0, 5'd3);
        add_row(OP_COMPLETE, 32'h0000_0100, 8'h80, 16'h0, 8'h0, 32'd109, 32'h0,
                0, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_ARM, 32'h0, 8'h0, 16'h0001, 8'h01, 32'd5000, 32'd0,
                0, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_COMPLETE, 32'hFFFF_FFFF, 8'hFF, 16'h0, 8'h0, 32'd5000, 32'h0,
                1, 0, 16'h0, 8'h0, 5'd4);
        add_row(OP_ARM, 32'h0, 8'h0, 16'h5A5A, 8'hA5, 32'h0, 32'hFFFF_FFFF,
                0, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_COMPLETE, 32'h0, 8'h0, 16'h0, 8'h0, 32'hFFFF_FFFE, 32'h0,
                0, 0, 16'h0, 8'h0, 5'd0);
        add_row(OP_LOOKUP, 32'h0, 8'h0, 16'h0, 8'h0, 32'h0, 32'h0,
                0, 0, 16'h0, 8'h0, 5'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = $urandom_range(1, 16);

        foreach (row_q[i]) begin
            send_word(row_q[i].w, row_q[i].typed, row_q[i].res);
            pace();
        end
        n_dir = words_sent;
        hold_until_drained();

        // The first stretch fills the table with distinct keys so that it runs full early.
        cur_phase = 0;
        mix = MIX_FILL;
        next_hold = n_dir + $urandom_range(80, 140);
        while (words_sent < n_dir + RANDOM_WORDS) begin
            if ((words_sent - n_dir) / MIX_LENGTH != cur_phase) begin
                cur_phase = (words_sent - n_dir) / MIX_LENGTH;
                mix = t_mix'($urandom_range(2));
            end
            pick = $urandom_range(99);
            case (mix)
                MIX_FILL: begin
                    if (pick < 55) begin
                        w = keyed_word(OP_SET);
                        w.device_id = pool_dev[fill_idx % POOL];
                        w.button = pool_btn[fill_idx % POOL];
                        fill_idx++;
                        issue(w);
                    end else if (pick < 70) begin
                        issue(keyed_word(OP_LOOKUP));
                    end else if (pick < 85) begin
                        pair_up();
                    end else if (pick < 93) begin
                        issue(keyed_word(OP_REMOVE));
                    end else begin
                        issue(noise_word());
                    end
                end
                MIX_DRAIN: begin
                    if (pick < 45) begin
                        issue(keyed_word(OP_REMOVE));
                    end else if (pick < 65) begin
                        issue(keyed_word(OP_LOOKUP));
                    end else if (pick < 75) begin
                        issue(keyed_word(OP_SET));
                    end else if (pick < 90) begin
                        pair_up();
                    end else begin
                        issue(noise_word());
                    end
                end
                default: begin
                    if (pick < 25) begin
                        issue(keyed_word(OP_SET));
                    end else if (pick < 45) begin
                        issue(keyed_word(OP_LOOKUP));
                    end else if (pick < 60) begin
                        issue(keyed_word(OP_REMOVE));
                    end else if (pick < 85) begin
                        pair_up();
                    end else begin
                        issue(noise_word());
                    end
                end
            endcase
            if (words_sent >= next_hold) begin
                hold_until_drained();
                next_hold = words_sent + $urandom_range(80, 140);
            end
        end

        if (in_valid) begin
            in_valid <= 1'b0;
        end
        guard = 0;
        while (pending_results.size() != 0 && guard < 4000) begin
            @(posedge clk);
            guard++;
        end
        repeat (ENTRIES + 8) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end

        $display("Sent %0d words (%0d directed), checked %0d results.",
                 words_sent, n_dir, results_seen);
        $display("Saw %0d lookup hits, %0d completed pairings, %0d stores refused when full.",
                 lookup_hits, pairings_done, full_refusals);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
